>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the layer image cache.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define ASSERT_NXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

>>> rtl/core/lic_pkg.sv
// Types and constants of the layer image cache.
// No dependencies; used by the interfaces, lic_ctrl, lic_datapath and the top level.
`timescale 1ns / 1ps

package lic_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int CAP_W       = 5;
    localparam int OP_W        = 2;
    localparam int KEY_W       = 16;
    localparam int DIM_W       = 16;
    localparam int HANDLE_W    = 32;
    localparam int PAYLOAD_W   = 2 * DIM_W + HANDLE_W;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = PADDR_W - 2;

    localparam logic [CAP_W-1:0]     CAP_RESET    = 5'd16;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_STORE  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_RESP,
        ST_PROBE,
        ST_COMMIT,
        ST_CLEAR
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;   // capture input transaction
        logic look;    // lookup compare, payload RAM read
        logic load;    // fill response register
        logic probe;   // store compare, evict oldest when full
        logic commit;  // store write, rank update
        logic clear;   // invalidate all entries
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic can_load;  // response register free this cycle
    } status_t;

endpackage

>>> rtl/core/lic_req_if.sv
// Request channel of the layer image cache: valid/ready plus the item fields.
// Depends on lic_pkg.
`timescale 1ns / 1ps

interface lic_req_if;
    logic                          valid;
    logic                          ready;
    logic [lic_pkg::OP_W-1:0]      operation;
    logic [lic_pkg::KEY_W-1:0]     layer_key;
    logic [lic_pkg::DIM_W-1:0]     width;
    logic [lic_pkg::DIM_W-1:0]     height;
    logic [lic_pkg::HANDLE_W-1:0]  image_handle;

    modport source (
        output valid, operation, layer_key, width, height, image_handle,
        input  ready
    );
    modport sink (
        input  valid, operation, layer_key, width, height, image_handle,
        output ready
    );
endinterface

>>> rtl/core/lic_rsp_if.sv
// Response channel of the layer image cache: valid/ready plus the result fields.
// Depends on lic_pkg.
`timescale 1ns / 1ps

interface lic_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [lic_pkg::KEY_W-1:0]     found_layer;
    logic [lic_pkg::DIM_W-1:0]     found_width;
    logic [lic_pkg::DIM_W-1:0]     found_height;
    logic [lic_pkg::HANDLE_W-1:0]  found_handle;

    modport source (
        output valid, hit, found_layer, found_width, found_height, found_handle,
        input  ready
    );
    modport sink (
        input  valid, hit, found_layer, found_width, found_height, found_handle,
        output ready
    );
endinterface

>>> rtl/core/lic_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/lic_ctrl.sv
// Sequencer of the layer image cache: dispatches each transaction by operation.
// Depends on lic_pkg.
`timescale 1ns / 1ps

module lic_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  logic [lic_pkg::OP_W-1:0] req_op,
    input  lic_pkg::status_t         status,
    output logic                     req_ready,
    output lic_pkg::cmd_t            cmd
);

    lic_pkg::state_t state_reg;
    lic_pkg::state_t state_next;
    logic            accept;

    function automatic lic_pkg::state_t dispatch(input logic [lic_pkg::OP_W-1:0] op);
        lic_pkg::state_t s;
        if (op == lic_pkg::OP_LOOKUP)
        begin
            s = lic_pkg::ST_LOOK;
        end
        else if (op == lic_pkg::OP_STORE)
        begin
            s = lic_pkg::ST_PROBE;
        end
        else if (op == lic_pkg::OP_CLEAR)
        begin
            s = lic_pkg::ST_CLEAR;
        end
        else
        begin
            s = lic_pkg::ST_IDLE;  // unused code: dropped
        end
        return s;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lic_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // outputs
    always_comb
    begin
        unique case (state_reg)
            lic_pkg::ST_IDLE,
            lic_pkg::ST_CLEAR,
            lic_pkg::ST_COMMIT: req_ready = 1'b1;
            lic_pkg::ST_RESP:   req_ready = status.can_load;
            default:            req_ready = 1'b0;
        endcase
        accept      = req_valid && req_ready;
        cmd.latch   = accept;
        cmd.look    = (state_reg == lic_pkg::ST_LOOK);
        cmd.load    = (state_reg == lic_pkg::ST_RESP) && status.can_load;
        cmd.probe   = (state_reg == lic_pkg::ST_PROBE);
        cmd.commit  = (state_reg == lic_pkg::ST_COMMIT);
        cmd.clear   = (state_reg == lic_pkg::ST_CLEAR);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lic_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = dispatch(req_op);
                end
            end
            lic_pkg::ST_LOOK:  state_next = lic_pkg::ST_RESP;
            lic_pkg::ST_PROBE: state_next = lic_pkg::ST_COMMIT;
            lic_pkg::ST_RESP:
            begin
                if (status.can_load)
                begin
                    state_next = accept ? dispatch(req_op) : lic_pkg::ST_IDLE;
                end
            end
            lic_pkg::ST_COMMIT,
            lic_pkg::ST_CLEAR:
            begin
                state_next = accept ? dispatch(req_op) : lic_pkg::ST_IDLE;
            end
            default: state_next = lic_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> rtl/core/lic_datapath.sv
// Datapath of the layer image cache: key/rank/valid cells, payload RAM,
// capacity register and response register. Depends on lic_pkg, lic_ram.
`timescale 1ns / 1ps

module lic_datapath #(
    parameter int ENTRIES = lic_pkg::ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lic_pkg::cmd_t                cmd,
    output lic_pkg::status_t             status,
    input  logic [lic_pkg::KEY_W-1:0]    in_key,
    input  logic [lic_pkg::DIM_W-1:0]    in_width,
    input  logic [lic_pkg::DIM_W-1:0]    in_height,
    input  logic [lic_pkg::HANDLE_W-1:0] in_handle,
    input  logic                         cfg_we,
    input  logic [lic_pkg::CAP_W-1:0]    cfg_wdata,
    output logic [lic_pkg::CAP_W-1:0]    capacity,
    input  logic                         rsp_ready,
    output logic                         rsp_valid,
    output logic                         hit,
    output logic [lic_pkg::KEY_W-1:0]    found_layer,
    output logic [lic_pkg::DIM_W-1:0]    found_width,
    output logic [lic_pkg::DIM_W-1:0]    found_height,
    output logic [lic_pkg::HANDLE_W-1:0] found_handle
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CW    = (CNT_W > lic_pkg::CAP_W) ? CNT_W : lic_pkg::CAP_W;
    localparam int PW    = lic_pkg::PAYLOAD_W;

    function automatic logic [CW-1:0] eff_cap(input logic [lic_pkg::CAP_W-1:0] c);
        logic [CW-1:0] e;
        e = CW'(c);
        if (e == '0)
        begin
            e = CW'(1);
        end
        else if (e > CW'(ENTRIES))
        begin
            e = CW'(ENTRIES);
        end
        return e;
    endfunction

    // entry cells
    logic [ENTRIES-1:0]         valid_reg, valid_next;
    logic [lic_pkg::KEY_W-1:0]  key_reg  [ENTRIES];
    logic [IDX_W-1:0]           rank_reg [ENTRIES];
    logic [IDX_W-1:0]           rank_next[ENTRIES];
    logic [lic_pkg::CAP_W-1:0]  cap_reg;

    // captured transaction
    logic [lic_pkg::KEY_W-1:0]  lat_key_reg;
    logic [PW-1:0]              lat_data_reg;

    // compare results
    logic                       hit_reg;
    logic [IDX_W-1:0]           hit_idx_reg;
    logic [IDX_W-1:0]           hit_rank_reg;

    // response register
    logic                       rsp_valid_reg;
    logic                       rsp_hit_reg;
    logic [lic_pkg::KEY_W-1:0]  rsp_layer_reg;
    logic [PW-1:0]              rsp_data_reg;

    logic [ENTRIES-1:0]         match;
    logic                       match_any;
    logic [IDX_W-1:0]           match_idx;
    logic [IDX_W-1:0]           match_rank;
    logic [IDX_W-1:0]           free_idx;
    logic [CNT_W-1:0]           count;
    logic [CW-1:0]              cap_eff;
    logic [CW-1:0]              cfg_thr;
    logic                       full;
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    logic [PW-1:0]              ram_rdata;
    logic                       can_load;

    always_comb
    begin
        match_any  = 1'b0;
        match_idx  = '0;
        match_rank = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]   = valid_reg[i] && (key_reg[i] == lat_key_reg);
            match_any  = match_any | match[i];
            match_idx  = match_idx | (match[i] ? IDX_W'(i) : '0);
            match_rank = match_rank | (rank_reg[i] & {IDX_W{match[i]}});
        end
    end

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign count   = CNT_W'($countones(valid_reg));
    assign cap_eff = eff_cap(cap_reg);
    assign cfg_thr = eff_cap(cfg_wdata);
    assign full    = (CW'(count) >= cap_eff);

    always_comb
    begin
        valid_next = valid_reg;
        priority if (cfg_we)
        begin
            // drop entries ranked at or beyond the new capacity
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (CW'(rank_reg[i]) >= cfg_thr)
                begin
                    valid_next[i] = 1'b0;
                end
            end
        end
        else if (cmd.clear)
        begin
            valid_next = '0;
        end
        else if (cmd.probe && !match_any && full)
        begin
            // evict the oldest to make room for a new key
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (CW'(rank_reg[i]) >= cap_eff - CW'(1))
                begin
                    valid_next[i] = 1'b0;
                end
            end
        end
        else if (cmd.commit && !hit_reg)
        begin
            valid_next[free_idx] = 1'b1;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (cmd.commit)
            begin
                if (hit_reg)
                begin
                    if (IDX_W'(i) == hit_idx_reg)
                    begin
                        rank_next[i] = '0;
                    end
                    else if (valid_reg[i] && (rank_reg[i] < hit_rank_reg))
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                else
                begin
                    if (IDX_W'(i) == free_idx)
                    begin
                        rank_next[i] = '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            cap_reg       <= lic_pkg::CAP_RESET;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.look || cmd.probe)
            begin
                hit_reg <= match_any;
            end
            if (cmd.load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            lat_key_reg  <= in_key;
            lat_data_reg <= {in_width, in_height, in_handle};
        end
        if (cmd.look || cmd.probe)
        begin
            hit_idx_reg  <= match_idx;
            hit_rank_reg <= match_rank;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_reg[i] <= rank_next[i];
            if (cmd.commit && !hit_reg && (IDX_W'(i) == free_idx))
            begin
                key_reg[i] <= lat_key_reg;
            end
        end
        if (cmd.load)
        begin
            rsp_hit_reg   <= hit_reg;
            rsp_layer_reg <= hit_reg ? lat_key_reg : '0;
            rsp_data_reg  <= hit_reg ? ram_rdata : '0;
        end
    end

    assign ram_we    = cmd.commit;
    assign ram_waddr = hit_reg ? hit_idx_reg : free_idx;

    lic_ram #(
        .WIDTH (PW),
        .DEPTH (ENTRIES)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (lat_data_reg),
        .re    (cmd.look),
        .raddr (match_idx),
        .rdata (ram_rdata)
    );

    assign can_load        = !rsp_valid_reg || rsp_ready;
    assign status.can_load = can_load;
    assign capacity        = cap_reg;
    assign rsp_valid       = rsp_valid_reg;
    assign hit             = rsp_hit_reg;
    assign found_layer     = rsp_layer_reg;
    assign found_width     = rsp_data_reg[PW-1 -: lic_pkg::DIM_W];
    assign found_height    = rsp_data_reg[lic_pkg::HANDLE_W +: lic_pkg::DIM_W];
    assign found_handle    = rsp_data_reg[lic_pkg::HANDLE_W-1:0];

endmodule

>>> rtl/core/layer_image_cache.sv
// Layer image cache: fully associative cache of image descriptors by layer.
// Top level; depends on lic_pkg, lic_req_if, lic_rsp_if, lic_ctrl,
// lic_datapath, lic_ram and assert_macros.svh.
//  - req: one transaction carries operation (lookup, store, clear), the
//    layer_key and, for a store, width, height and image_handle.
//  - rsp: one transaction per lookup only: hit and the stored fields, all zero
//    on a miss. Stores, clears and unused codes answer nothing.
//  - APB: capacity at byte address 0 (5 bits, reset 16). A write drops entries
//    ranked at or past the new capacity at once; write only while idle.
//  - lookup: compare and payload RAM read in the cycle after acceptance, then
//    the response register loads in the response step once free or draining.
//    A store runs a compare/evict step and a write step, a clear the clear step.
//  - the next transaction is taken in the last step of the current one (the
//    response, write or clear step); no new one is taken in the look step of
//    a lookup, for the registered RAM read, or the compare/evict step of a store.
//  - a stalled receiver holds the response register; stores and clears keep
//    going, and the next lookup waits in its response step until it frees.
//  - reset empties the cache and sets capacity to 16; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module layer_image_cache #(
    parameter int ENTRIES = lic_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    lic_req_if.sink                     req,
    lic_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lic_pkg::PADDR_W-1:0] paddr,
    input  logic [lic_pkg::PDATA_W-1:0] pwdata,
    output logic [lic_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    lic_pkg::cmd_t              cmd;
    lic_pkg::status_t           status;
    logic                       req_ready;
    logic                       cfg_we;
    logic                       reg_sel;
    logic [lic_pkg::CAP_W-1:0]  capacity;

    // APB: zero wait states, register index is paddr above the byte lanes
    assign pready  = 1'b1;
    assign reg_sel = (paddr[lic_pkg::PADDR_W-1:2] == lic_pkg::REG_CAPACITY);
    assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? lic_pkg::PDATA_W'(capacity) : '0;

    assign req.ready = req_ready;

    lic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.operation),
        .status    (status),
        .req_ready (req_ready),
        .cmd       (cmd)
    );

    lic_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_key       (req.layer_key),
        .in_width     (req.width),
        .in_height    (req.height),
        .in_handle    (req.image_handle),
        .cfg_we       (cfg_we),
        .cfg_wdata    (pwdata[lic_pkg::CAP_W-1:0]),
        .capacity     (capacity),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .hit          (rsp.hit),
        .found_layer  (rsp.found_layer),
        .found_width  (rsp.found_width),
        .found_height (rsp.found_height),
        .found_handle (rsp.found_handle)
    );

    // at most one entry-state operation per cycle
    `ASSERT_IMP(a_cmd_exclusive, clk, rst_n, 1'b1, $onehot0({cmd.look, cmd.probe, cmd.commit, cmd.clear}))
    // response register is loaded only when it is free or being drained
    `ASSERT_IMP(a_load_room, clk, rst_n, cmd.load, !rsp.valid || rsp.ready)
    // a store blocks the request side during its compare/evict cycle
    `ASSERT_NXT(a_store_busy, clk, rst_n, cmd.latch && (req.operation == lic_pkg::OP_STORE), !req_ready)

endmodule

>>> tb/layer_image_cache_tb.sv
// Self-checking testbench of the layer image cache: directed and random traffic
// on the request channel, APB capacity writes, responses checked against a predictor.
// Depends on lic_pkg, lic_req_if, lic_rsp_if and the layer_image_cache RTL.
`timescale 1ns / 1ps

module layer_image_cache_tb;

    localparam int NUM_SLOTS = lic_pkg::ENTRIES_DEF;

    // Operation code that the block must ignore without touching state.
    localparam logic [lic_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Byte addresses on the APB port: the capacity register, and one past the
    // register map that must be ignored.
    localparam logic [lic_pkg::PADDR_W-1:0] ADDR_CAPACITY = {lic_pkg::REG_CAPACITY, 2'b00};
    localparam logic [lic_pkg::PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

    // A store ends with its compare/evict and write steps and answers nothing; once
    // no response is outstanding, wait this long before touching the register.
    localparam int DRAIN_CYCLES = 8;

    localparam int PHASE_ITEMS = 113;

    typedef struct packed {
        logic                         hit;
        logic [lic_pkg::KEY_W-1:0]    layer;
        logic [lic_pkg::DIM_W-1:0]    w;
        logic [lic_pkg::DIM_W-1:0]    h;
        logic [lic_pkg::HANDLE_W-1:0] handle;
    } lookup_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [lic_pkg::PADDR_W-1:0] paddr;
    logic [lic_pkg::PDATA_W-1:0] pwdata;
    logic [lic_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    lic_req_if req_ch ();
    lic_rsp_if rsp_ch ();

    layer_image_cache dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Random idling on both channels; switched off for one long phase.
    bit traffic_gaps;
    int fail_count;
    int key_pool;

    // Lookup results still owed by the block, oldest first.
    lookup_result_t pending_lookups[$];

    //------------------------------------------------------------------------
    // Predictor state: a mirror of the cache contents and the capacity
    // register. slot_age counts the live entries written more recently, so
    // age 0 is the newest and the oldest has age live_count-1.
    //------------------------------------------------------------------------
    logic [lic_pkg::CAP_W-1:0]    cap_reg;
    bit                           slot_live   [NUM_SLOTS];
    logic [lic_pkg::KEY_W-1:0]    slot_key    [NUM_SLOTS];
    logic [lic_pkg::DIM_W-1:0]    slot_w      [NUM_SLOTS];
    logic [lic_pkg::DIM_W-1:0]    slot_h      [NUM_SLOTS];
    logic [lic_pkg::HANDLE_W-1:0] slot_handle [NUM_SLOTS];
    int                           slot_age    [NUM_SLOTS];

    // Capacity zero behaves as one, values past the slot count as the slot count.
    function automatic int eff_capacity();
        int c;
        c = int'(cap_reg);
        if (c < 1) c = 1;
        if (c > NUM_SLOTS) c = NUM_SLOTS;
        return c;
    endfunction

    // Drop every live entry whose age is at or past the limit.
    function automatic void drop_aged(input int limit);
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_live[i] && slot_age[i] >= limit) slot_live[i] = 1'b0;
    endfunction

    function automatic void model_store(input logic [lic_pkg::KEY_W-1:0] key,
                                        input logic [lic_pkg::DIM_W-1:0] w,
                                        input logic [lic_pkg::DIM_W-1:0] h,
                                        input logic [lic_pkg::HANDLE_W-1:0] hd);
        int slot;
        int live_n;
        int old_age;
        slot = -1;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_live[i] && slot_key[i] == key) slot = i;
        if (slot >= 0)
        begin
            // Present key: rewrite in place, only the newer entries age by one.
            old_age = slot_age[slot];
            for (int i = 0; i < NUM_SLOTS; i++)
                if (slot_live[i] && slot_age[i] < old_age) slot_age[i]++;
        end
        else
        begin
            // New key: a full cache loses its oldest entry first.
            live_n = 0;
            for (int i = 0; i < NUM_SLOTS; i++)
                if (slot_live[i]) live_n++;
            if (live_n >= eff_capacity()) drop_aged(eff_capacity() - 1);
            for (int i = 0; i < NUM_SLOTS; i++)
                if (slot_live[i]) slot_age[i]++;
            for (int i = 0; i < NUM_SLOTS; i++)
                if (!slot_live[i] && slot < 0) slot = i;
            slot_live[slot] = 1'b1;
            slot_key[slot]  = key;
        end
        slot_w[slot]      = w;
        slot_h[slot]      = h;
        slot_handle[slot] = hd;
        slot_age[slot]    = 0;
    endfunction

    // Lookup leaves the age order alone; a miss answers all zero.
    function automatic lookup_result_t model_lookup(input logic [lic_pkg::KEY_W-1:0] key);
        lookup_result_t res;
        res = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_live[i] && slot_key[i] == key)
            begin
                res.hit    = 1'b1;
                res.layer  = slot_key[i];
                res.w      = slot_w[i];
                res.h      = slot_h[i];
                res.handle = slot_handle[i];
            end
        return res;
    endfunction

    function automatic void model_accept(input logic [lic_pkg::OP_W-1:0] op,
                                         input logic [lic_pkg::KEY_W-1:0] key,
                                         input logic [lic_pkg::DIM_W-1:0] w,
                                         input logic [lic_pkg::DIM_W-1:0] h,
                                         input logic [lic_pkg::HANDLE_W-1:0] hd);
        unique case (op)
            lic_pkg::OP_LOOKUP: pending_lookups = {pending_lookups, model_lookup(key)};
            lic_pkg::OP_STORE:  model_store(key, w, h, hd);
            lic_pkg::OP_CLEAR:  for (int i = 0; i < NUM_SLOTS; i++) slot_live[i] = 1'b0;
            default:            ;
        endcase
    endfunction

    //------------------------------------------------------------------------
    // Clock and the receiving side of the response channel
    //------------------------------------------------------------------------
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the response channel now and then; inputs move on the falling edge.
    always @(negedge clk)
    begin
        rsp_ch.ready <= !(traffic_gaps && $urandom_range(99) < 15);
    end

    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] act_v);
        fail_count++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                 $time, what, exp_v, act_v);
    endtask

    // Every response transaction is matched with the oldest owed lookup.
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                fail_count++;
                $display("%0t ns: response with no lookup pending, expected none, actual layer %0h",
                         $time, rsp_ch.found_layer);
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (rsp_ch.hit !== want.hit)
                    report_mismatch("hit", 64'(want.hit), 64'(rsp_ch.hit));
                if (rsp_ch.found_layer !== want.layer)
                    report_mismatch("found_layer", 64'(want.layer), 64'(rsp_ch.found_layer));
                if (rsp_ch.found_width !== want.w)
                    report_mismatch("found_width", 64'(want.w), 64'(rsp_ch.found_width));
                if (rsp_ch.found_height !== want.h)
                    report_mismatch("found_height", 64'(want.h), 64'(rsp_ch.found_height));
                if (rsp_ch.found_handle !== want.handle)
                    report_mismatch("found_handle", 64'(want.handle),
                                    64'(rsp_ch.found_handle));
            end
        end
    end

    //------------------------------------------------------------------------
    // Request side. Each task is entered and left just after a falling edge.
    //------------------------------------------------------------------------

    // Offer one transaction, with an occasional idle gap in front of it, and
    // hand it to the predictor at the rising edge where it is accepted.
    task automatic send_item(input logic [lic_pkg::OP_W-1:0] op,
                             input logic [lic_pkg::KEY_W-1:0] key,
                             input logic [lic_pkg::DIM_W-1:0] w,
                             input logic [lic_pkg::DIM_W-1:0] h,
                             input logic [lic_pkg::HANDLE_W-1:0] hd);
        int gap;
        gap = 0;
        if (traffic_gaps && $urandom_range(99) < 15) gap = $urandom_range(3, 1);
        repeat (gap)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.layer_key    <= key;
        req_ch.width        <= w;
        req_ch.height       <= h;
        req_ch.image_handle <= hd;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        model_accept(op, key, w, h, hd);
        @(negedge clk);
    endtask

    // Store with random content, the common case of the directed tests.
    task automatic store_random(input logic [lic_pkg::KEY_W-1:0] key);
        send_item(lic_pkg::OP_STORE, key, lic_pkg::DIM_W'($urandom),
                  lic_pkg::DIM_W'($urandom), $urandom);
    endtask

    // Quiet the request channel and let all outstanding work finish; stores
    // answer nothing, so a fixed tail covers the last one.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_lookups.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // APB write (setup + access), then a read back of the capacity register.
    task automatic write_reg(input logic [lic_pkg::PADDR_W-1:0] addr,
                             input logic [lic_pkg::PDATA_W-1:0] data);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if ((addr >> 2) == lic_pkg::REG_CAPACITY)
        begin
            // Register keeps the written bits; entries past the new limit go.
            cap_reg = data[lic_pkg::CAP_W-1:0];
            drop_aged(eff_capacity());
        end
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_CAPACITY;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[lic_pkg::CAP_W-1:0] !== cap_reg)
            report_mismatch("capacity read back", 64'(cap_reg),
                            64'(prdata[lic_pkg::CAP_W-1:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Capacity write with random bits above the register field.
    task automatic write_capacity(input int cap);
        logic [lic_pkg::PDATA_W-1:0] d;
        d = $urandom;
        d[lic_pkg::CAP_W-1:0] = lic_pkg::CAP_W'(cap);
        write_reg(ADDR_CAPACITY, d);
    endtask

    function automatic logic [lic_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 88) return lic_pkg::KEY_W'($urandom_range(key_pool, 0));
        if (r < 96) return lic_pkg::KEY_W'($urandom);
        return r[0] ? {lic_pkg::KEY_W{1'b1}} : {lic_pkg::KEY_W{1'b0}};
    endfunction

    //------------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------------

    // Miss on an empty cache, field extremes, overwrite, ignored code, clear.
    task automatic test_basics();
        send_item(lic_pkg::OP_LOOKUP, '0, '0, '0, '0);
        send_item(lic_pkg::OP_STORE, '0, '0, '0, '0);
        send_item(lic_pkg::OP_STORE, '1, '1, '1, '1);
        send_item(lic_pkg::OP_LOOKUP, '1, '0, '0, '0);
        send_item(lic_pkg::OP_STORE, '0, 16'h1234, 16'h5678, 32'hdead_beef);
        send_item(lic_pkg::OP_LOOKUP, '0, '1, '1, '1);
        // unused code with a live key: nothing changes, nothing answers
        send_item(OP_UNUSED, '1, '0, '0, '0);
        send_item(lic_pkg::OP_CLEAR, '1, '0, '0, '0);
        send_item(lic_pkg::OP_LOOKUP, '0, '0, '0, '0);
    endtask

    // Full cache of two: a new key evicts the oldest; rewriting a present key
    // makes it newest without an eviction.
    task automatic test_eviction_order();
        write_capacity(2);
        store_random(16'd10);
        store_random(16'd11);
        store_random(16'd12);
        send_item(lic_pkg::OP_LOOKUP, 16'd10, '0, '0, '0);
        store_random(16'd11);
        store_random(16'd13);
        send_item(lic_pkg::OP_LOOKUP, 16'd12, '0, '0, '0);
        send_item(lic_pkg::OP_LOOKUP, 16'd11, '0, '0, '0);
    endtask

    // Lowering capacity trims the oldest entries at once; zero acts as one,
    // values past the slot count act as the slot count; unmapped writes do nothing.
    task automatic test_capacity_limits();
        write_capacity(16);
        store_random(16'd20);
        store_random(16'd21);
        store_random(16'd22);
        write_capacity(2);
        send_item(lic_pkg::OP_LOOKUP, 16'd21, '0, '0, '0);
        write_capacity(0);
        store_random(16'd23);
        send_item(lic_pkg::OP_LOOKUP, 16'd22, '0, '0, '0);
        write_capacity(31);
        write_reg(ADDR_UNMAPPED, $urandom);
        store_random(16'd24);
        send_item(lic_pkg::OP_LOOKUP, 16'd23, '0, '0, '0);
    endtask

    // Phases of random traffic, each at its own capacity. Entries carry over
    // from phase to phase, so a capacity change that lowers the limit can trim a live cache.
    task automatic test_random_traffic();
        int caps[10];
        int sent;
        int r;
        logic [lic_pkg::OP_W-1:0] op;
        caps = '{16, 1, 0, 31, 17, 8, 3, 2, 0, 16};
        caps[8] = $urandom_range(15, 2);
        for (int p = 0; p < 10; p++)
        begin
            write_capacity(caps[p]);
            if (p == 6) write_reg(ADDR_UNMAPPED, $urandom);
            traffic_gaps = (p != 4);
            // key pool a bit larger than the capacity: hits, misses and evictions
            key_pool = eff_capacity() + eff_capacity() / 2 + 1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                if (r < 48)      op = lic_pkg::OP_LOOKUP;
                else if (r < 93) op = lic_pkg::OP_STORE;
                else if (r < 96) op = lic_pkg::OP_CLEAR;
                else             op = OP_UNUSED;
                send_item(op, pick_key(), lic_pkg::DIM_W'($urandom),
                          lic_pkg::DIM_W'($urandom), $urandom);
                if (op != OP_UNUSED) sent++;
            end
        end
        traffic_gaps = 1'b1;
    endtask

    //------------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------------
    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = lic_pkg::OP_LOOKUP;
        req_ch.layer_key    = '0;
        req_ch.width        = '0;
        req_ch.height       = '0;
        req_ch.image_handle = '0;
        rsp_ch.ready        = 1'b0;
        traffic_gaps        = 1'b1;
        fail_count          = 0;
        key_pool            = NUM_SLOTS;

        // predictor reset: empty cache, capacity at its reset value
        cap_reg = lic_pkg::CAP_RESET;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_live[i]   = 1'b0;
            slot_key[i]    = '0;
            slot_w[i]      = '0;
            slot_h[i]      = '0;
            slot_handle[i] = '0;
            slot_age[i]    = 0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_basics();
        test_eviction_order();
        test_capacity_limits();
        test_random_traffic();

        wait_idle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/lic_pkg.sv
rtl/core/lic_req_if.sv
rtl/core/lic_rsp_if.sv
rtl/core/lic_ram.sv
rtl/core/lic_ctrl.sv
rtl/core/lic_datapath.sv
rtl/core/layer_image_cache.sv
tb/layer_image_cache_tb.sv
